// File: rtl/pe_base_reloc_parser_macros.svh
// ----------------------------------------------------------------------------
// pe_base_reloc_parser_macros.svh
// assertion helpers shared by the relocation parser modules
// ----------------------------------------------------------------------------
`ifndef PE_BASE_RELOC_PARSER_MACROS_SVH
`define PE_BASE_RELOC_PARSER_MACROS_SVH

// property checked on every clock edge outside reset
`define PBR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pbr assertion failed");

// condition that must never be true outside reset
`define PBR_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pbr forbidden condition");

`endif

// File: rtl/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg
// types and constants of the base relocation parser
// ----------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

    localparam logic [31:0] HDR_BYTES   = 32'd8;
    localparam int          OFFSET_BITS = 12;
    localparam int          RESULT_DEPTH = 4;

    // result kind codes
    localparam logic [2:0] K_ENTRY      = 3'd0;
    localparam logic [2:0] K_CLEAN      = 3'd1;
    localparam logic [2:0] K_ZERO       = 3'd2;
    localparam logic [2:0] K_INVALID    = 3'd3;
    localparam logic [2:0] K_INCOMPLETE = 3'd4;
    localparam logic [2:0] K_TRUNCATED  = 3'd5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_ENTRIES = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] target_address;
        logic [3:0]  reloc_kind;
        logic        last_of_run;
    } result_t;

    // results produced by one accepted byte: an entry, then the status
    typedef struct packed {
        logic    ent_valid;
        logic    stat_valid;
        result_t ent;
        result_t stat;
    } step_out_t;

endpackage

`default_nettype wire

// File: rtl/pbr_in_if.sv
// ----------------------------------------------------------------------------
// pbr_in_if
// byte stream channel of the relocation parser
// ----------------------------------------------------------------------------
`default_nettype none

interface pbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/pbr_out_if.sv
// ----------------------------------------------------------------------------
// pbr_out_if
// result channel of the relocation parser
// ----------------------------------------------------------------------------
`default_nettype none

interface pbr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] target_address;
    logic [3:0]  reloc_kind;
    logic        last_of_run;

    modport source (output valid, output kind, output target_address,
                    output reloc_kind, output last_of_run, input ready);
    modport sink   (input valid, input kind, input target_address,
                    input reloc_kind, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/pbr_core.sv
// ----------------------------------------------------------------------------
// pbr_core
// block header collection, entry splitting and end status per byte
// ----------------------------------------------------------------------------
`default_nettype none

`include "pe_base_reloc_parser_macros.svh"

module pbr_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              final_byte,
    output pbr_pkg::step_out_t     step
);
    import pbr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] page_reg, page_next;
    logic [31:0] size_reg, size_next;
    logic [7:0]  low_reg, low_next;
    logic [2:0]  stop_reg, stop_next;

    logic [2:0]  hdr_pos;
    logic [31:0] size_full;
    logic [31:0] count_inc;
    logic [15:0] word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            page_reg  <= '0;
            size_reg  <= '0;
            low_reg   <= '0;
            stop_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            page_reg  <= page_next;
            size_reg  <= size_next;
            low_reg   <= low_next;
            stop_reg  <= stop_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        page_next  = page_reg;
        size_next  = size_reg;
        low_next   = low_reg;
        stop_next  = stop_reg;
        step       = '0;
        hdr_pos    = count_reg[2:0];
        size_full  = {data_byte, size_reg[23:0]};
        count_inc  = count_reg + 32'd1;
        word       = {data_byte, low_reg};

        case (phase_reg)
            PH_HEADER:
            begin
                // lane write, first byte of each word clears the rest
                if (!hdr_pos[2])
                begin
                    if (hdr_pos[1:0] == 2'd0)
                        page_next = {24'd0, data_byte};
                    else
                        page_next[{hdr_pos[1:0], 3'b000} +: 8] = data_byte;
                end
                else
                begin
                    if (hdr_pos[1:0] == 2'd0)
                        size_next = {24'd0, data_byte};
                    else
                        size_next[{hdr_pos[1:0], 3'b000} +: 8] = data_byte;
                end
                count_next = {29'd0, hdr_pos} + 32'd1;
                if (hdr_pos == 3'd7)
                begin
                    if (size_full == 32'd0)
                    begin
                        phase_next = PH_STOPPED;
                        stop_next  = K_ZERO;
                    end
                    else if (size_full < HDR_BYTES)
                    begin
                        phase_next = PH_STOPPED;
                        stop_next  = K_INVALID;
                    end
                    else if (size_full == HDR_BYTES)
                        count_next = '0;
                    else
                        phase_next = PH_ENTRIES;
                end
            end
            PH_ENTRIES:
            begin
                // header is even length, so odd count means high byte of an entry
                if (count_reg[0])
                begin
                    step.ent_valid = 1'b1;
                    step.ent.kind = K_ENTRY;
                    step.ent.target_address =
                        page_reg + {20'd0, word[OFFSET_BITS-1:0]};
                    step.ent.reloc_kind = word[15:OFFSET_BITS];
                    step.ent.last_of_run = 1'b0;
                end
                else if (count_inc < size_reg)
                    low_next = data_byte;
                count_next = count_inc;
                if (count_inc >= size_reg)
                begin
                    phase_next = PH_HEADER;
                    count_next = '0;
                end
            end
            PH_STOPPED:
            begin
                phase_next = PH_STOPPED;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        if (final_byte)
        begin
            step.stat_valid       = 1'b1;
            step.stat.last_of_run = 1'b1;
            if (phase_next == PH_STOPPED)
                step.stat.kind = stop_next;
            else if (phase_next == PH_ENTRIES)
                step.stat.kind = K_TRUNCATED;
            else if (count_next == 32'd0)
                step.stat.kind = K_CLEAN;
            else
                step.stat.kind = K_INCOMPLETE;
            phase_next = PH_HEADER;
            count_next = '0;
            page_next  = '0;
            size_next  = '0;
            low_next   = '0;
            stop_next  = '0;
        end

        if (!accept)
        begin
            step.ent_valid  = 1'b0;
            step.stat_valid = 1'b0;
        end
    end

    `PBR_ASSERT(a_final_restarts, accept && final_byte |=> phase_reg == PH_HEADER && count_reg == '0)
    `PBR_ASSERT(a_entry_on_odd, step.ent_valid |-> phase_reg == PH_ENTRIES && count_reg[0])
    `PBR_ASSERT(a_stopped_has_reason, phase_reg == PH_STOPPED |-> stop_reg == K_ZERO || stop_reg == K_INVALID)

endmodule

`default_nettype wire

// File: rtl/pbr_fifo.sv
// ----------------------------------------------------------------------------
// pbr_fifo
// small result queue, takes up to two results per cycle and gives one
// ----------------------------------------------------------------------------
`default_nettype none

`include "pe_base_reloc_parser_macros.svh"

module pbr_fifo #(
    parameter int Depth = pbr_pkg::RESULT_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pbr_pkg::step_out_t step,
    input  wire logic               pop,
    output pbr_pkg::result_t        head,
    output logic                    not_empty,
    output logic                    has_room
);
    import pbr_pkg::*;

    localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    result_t         mem_reg [Depth];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   wr_ptr_two;
    logic [1:0]      push_n;
    logic            push_two;
    result_t         first_res;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        logic [PW-1:0] r;
        if (ptr == PW'(Depth - 1))
            r = '0;
        else
            r = ptr + PW'(1);
        return r;
    endfunction

    always_comb
    begin
        push_n      = {1'b0, step.ent_valid} + {1'b0, step.stat_valid};
        push_two    = step.ent_valid && step.stat_valid;
        first_res   = step.ent_valid ? step.ent : step.stat;
        wr_ptr_two  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push_two)
            wr_ptr_next = ptr_inc(wr_ptr_two);
        else if (push_n != 2'd0)
            wr_ptr_next = wr_ptr_two;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_n) - CW'(pop);
        head        = mem_reg[rd_ptr_reg];
        not_empty   = count_reg != '0;
        // room for a full beat's worth of results
        has_room    = count_reg <= CW'(Depth - 2);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= first_res;
        if (push_two)
            mem_reg[wr_ptr_two] <= step.stat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PBR_NEVER(a_no_overflow, count_reg > CW'(Depth))
    `PBR_ASSERT(a_pop_nonempty, pop |-> count_reg != '0)
    `PBR_ASSERT(a_two_fit, push_two |-> count_reg <= CW'(Depth - 2))

endmodule

`default_nettype wire

// File: rtl/pe_base_reloc_parser.sv
// ----------------------------------------------------------------------------
// pe_base_reloc_parser
// PE base relocation section parser, one byte per beat
// ----------------------------------------------------------------------------
// Takes one section byte per cycle, little-endian, with final_byte on the
// last one, and turns each 16-bit entry into page address plus offset with
// its type. All parsing for a byte is done in the cycle it is accepted, so
// a byte can be taken every cycle; results are registered into a Depth-entry
// queue and appear on the result channel from there, in the order made.
// A byte makes at most two results (an entry, then the final status), and
// stream.ready drops only while the queue has fewer than two free slots,
// which happens only when the result sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_base_reloc_parser #(
    parameter int Depth = pbr_pkg::RESULT_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pbr_in_if.sink     stream,
    pbr_out_if.source  result
);
    import pbr_pkg::*;

    step_out_t step;
    result_t   head;
    logic      accept;
    logic      pop;
    logic      not_empty;
    logic      has_room;

    assign stream.ready = has_room;
    assign accept       = stream.valid && has_room;
    assign pop          = not_empty && result.ready;

    pbr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (stream.data_byte),
        .final_byte (stream.final_byte),
        .step       (step)
    );

    pbr_fifo #(
        .Depth (Depth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign result.valid          = not_empty;
    assign result.kind           = head.kind;
    assign result.target_address = head.target_address;
    assign result.reloc_kind     = head.reloc_kind;
    assign result.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// File: sim/pe_base_reloc_parser_tb.sv
// ----------------------------------------------------------------------------
// pe_base_reloc_parser_tb
// self-checking bench for the base relocation section parser
// ----------------------------------------------------------------------------
// Streams whole relocation sections through the byte channel and checks every
// result beat against an in-bench parser of the same format. A short directed
// section set hits the field extremes and the stop cases. Random sections
// follow, mostly well formed with random pages, sizes and entries, ended
// cleanly or cut short in every way the format allows. Three traffic phases
// vary idle rates on both sides, one long result stall backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_base_reloc_parser_tb;
    import pbr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } section_byte_t;

    logic clk;
    logic rst_n;

    pbr_in_if  in_ch ();
    pbr_out_if out_ch ();

    pe_base_reloc_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .result (out_ch)
    );

    // stimulus and expectations
    section_byte_t section_bytes[$];
    logic [7:0]    run_bytes[$];
    result_t       reloc_results_due[$];
    int            bytes_planned;

    // traffic shaping
    int send_idle_pct = 11;
    int recv_idle_pct = 47;
    bit hold_request;
    bit hold_taken;
    int hold_left;

    int mismatch_count;

    // parser state of the prediction
    phase_t      par_phase;
    logic [31:0] par_count;
    logic [31:0] par_page;
    logic [31:0] par_size;
    logic [7:0]  par_low;
    logic [2:0]  par_stop;

    section_byte_t next_byte;
    result_t       want;
    result_t       got;

    always #2 clk = ~clk;

    task automatic clear_parser();
        par_phase = PH_HEADER;
        par_count = '0;
        par_page  = '0;
        par_size  = '0;
        par_low   = '0;
        par_stop  = '0;
    endtask

    task automatic stash_due(input result_t r);
        reloc_results_due.insert(reloc_results_due.size(), r);
    endtask

    task automatic stash_byte(input logic [7:0] b);
        run_bytes.insert(run_bytes.size(), b);
    endtask

    // walks one section byte through the parser and queues what it yields
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [31:0] p;
        logic [15:0] word;
        result_t     r;
        if (par_phase == PH_HEADER)
        begin
            p = par_count & 32'd7;
            if (p < 32'd4)
            begin
                if (p == 32'd0)
                    par_page = '0;
                par_page = par_page | ({24'd0, b} << (8 * p));
            end
            else
            begin
                if (p == 32'd4)
                    par_size = '0;
                par_size = par_size | ({24'd0, b} << (8 * (p - 32'd4)));
            end
            par_count = p + 32'd1;
            if (par_count == HDR_BYTES)
            begin
                if (par_size == 32'd0)
                begin
                    par_phase = PH_STOPPED;
                    par_stop  = K_ZERO;
                end
                else if (par_size < HDR_BYTES)
                begin
                    par_phase = PH_STOPPED;
                    par_stop  = K_INVALID;
                end
                else if (par_size == HDR_BYTES)
                    par_count = '0;
                else
                    par_phase = PH_ENTRIES;
            end
        end
        else if (par_phase == PH_ENTRIES)
        begin
            p = par_count;
            if (((p - HDR_BYTES) & 32'd1) != 32'd0)
            begin
                word = {b, par_low};
                r.kind           = K_ENTRY;
                r.target_address = par_page + {20'd0, word[11:0]};
                r.reloc_kind     = word[15:12];
                r.last_of_run    = 1'b0;
                stash_due(r);
            end
            else if (p + 32'd1 < par_size)
                par_low = b;
            par_count = p + 32'd1;
            if (par_count >= par_size)
            begin
                par_phase = PH_HEADER;
                par_count = '0;
            end
        end

        if (fin)
        begin
            if (par_phase == PH_STOPPED)
                r.kind = par_stop;
            else if (par_phase == PH_ENTRIES)
                r.kind = K_TRUNCATED;
            else if (par_count == 32'd0)
                r.kind = K_CLEAN;
            else
                r.kind = K_INCOMPLETE;
            r.target_address = '0;
            r.reloc_kind     = '0;
            r.last_of_run    = 1'b1;
            stash_due(r);
            clear_parser();
        end
    endtask

    task automatic add_word(input logic [31:0] w);
        stash_byte(w[7:0]);
        stash_byte(w[15:8]);
        stash_byte(w[23:16]);
        stash_byte(w[31:24]);
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++)
            stash_byte(8'($urandom_range(0, 255)));
    endtask

    // hands the collected run to the driver, marking its last byte
    task automatic close_run();
        section_byte_t sb;
        while (run_bytes.size() != 0)
        begin
            sb.data = run_bytes.pop_front();
            sb.fin  = (run_bytes.size() == 0);
            section_bytes.insert(section_bytes.size(), sb);
            bytes_planned++;
        end
    endtask

    // pages near the top of the address space make the sum wrap
    function automatic logic [31:0] random_page();
        if ($urandom_range(0, 3) == 0)
            return {20'hFFFFF, 12'($urandom_range(0, 4095))};
        return $urandom;
    endfunction

    task automatic add_random_run();
        int          nblk;
        logic [31:0] size;
        nblk = $urandom_range(0, 3);
        for (int k = 0; k < nblk; k++)
        begin
            size = 32'd8 + 32'(2 * $urandom_range(0, 10)) + 32'($urandom_range(0, 3) == 0);
            add_word(random_page());
            add_word(size);
            add_noise(int'(size) - 8);
        end
        case ($urandom_range(0, 9))
            5:
            begin
                // cut off inside a block, possibly right at the end of its header
                add_word(random_page());
                add_word($urandom | 32'd16);
                add_noise($urandom_range(0, 7));
            end
            6: add_noise($urandom_range(1, 7));
            7:
            begin
                add_word(random_page());
                add_word(32'd0);
                add_noise($urandom_range(0, 6));
            end
            8:
            begin
                add_word(random_page());
                add_word(32'($urandom_range(1, 7)));
                add_noise($urandom_range(0, 6));
            end
            9: add_noise($urandom_range(1, 12));
            default:
            begin
                if (run_bytes.size() == 0)
                begin
                    add_word(random_page());
                    add_word(HDR_BYTES);
                end
            end
        endcase
        close_run();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (section_bytes.size() != 0 || in_ch.valid || reloc_results_due.size() != 0);
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (section_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_byte = section_bytes.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.data_byte  <= next_byte.data;
                in_ch.final_byte <= next_byte.fin;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result sink with one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken   <= 1'b1;
            hold_left    <= 300;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict on each byte beat, check each result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.data_byte, in_ch.final_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind           = out_ch.kind;
                got.target_address = out_ch.target_address;
                got.reloc_kind     = out_ch.reloc_kind;
                got.last_of_run    = out_ch.last_of_run;
                if (reloc_results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: kind %0d addr %h type %0d last %0b",
                                 got.kind, got.target_address, got.reloc_kind,
                                 got.last_of_run);
                end
                else
                begin
                    want = reloc_results_due.pop_front();
                    if (got.kind != want.kind || got.target_address != want.target_address
                        || got.reloc_kind != want.reloc_kind
                        || got.last_of_run != want.last_of_run)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result beat differs: expected kind %0d addr %h type %0d",
                                      " last %0b, got kind %0d addr %h type %0d last %0b"},
                                     want.kind, want.target_address, want.reloc_kind,
                                     want.last_of_run, got.kind, got.target_address,
                                     got.reloc_kind, got.last_of_run);
                    end
                end
            end
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready     = 1'b0;
        hold_request     = 1'b0;
        hold_taken       = 1'b0;
        hold_left        = 0;
        mismatch_count   = 0;
        bytes_planned    = 0;
        clear_parser();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wrapping address, type and byte extremes, odd trailing byte, clean end
        add_word(32'hFFFFF800);
        add_word(32'd13);
        stash_byte(8'hFF);
        stash_byte(8'hFF);
        stash_byte(8'h00);
        stash_byte(8'h00);
        stash_byte(8'h5A);
        close_run();
        // empty block, then zero size with a byte after the stop
        add_word(32'h00001000);
        add_word(HDR_BYTES);
        add_word(32'h12345678);
        add_word(32'd0);
        stash_byte(8'hC3);
        close_run();
        // size below a header
        add_word(32'hA5A5A5A5);
        add_word(32'd7);
        close_run();
        // section ends inside a header
        stash_byte(8'h80);
        close_run();

        while (bytes_planned < 630)
            add_random_run();
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 11;
        while (bytes_planned < 1240)
            add_random_run();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_planned < 1830)
            add_random_run();
        hold_request = 1'b1;
        wait_drained();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && reloc_results_due.size() == 0)
            $display("pe_base_reloc_parser: match");
        else
            $display("pe_base_reloc_parser: mismatch");
        $finish;
    end

    initial
    begin
        #400000;
        $display("pe_base_reloc_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
